### rtl/pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants for the PCM sample encoder
// Format codes, register indexes, companding constants and the result record.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int AMP_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 2;
	localparam int FMT_W      = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam int MAG_W      = 15;
	localparam int SEG_W      = 3;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 24;

	// sample_format codes; 10 and up mean unsupported
	localparam logic [FMT_W-1:0] FMT_S8         = 4'd0;
	localparam logic [FMT_W-1:0] FMT_U8         = 4'd1;
	localparam logic [FMT_W-1:0] FMT_S16BE      = 4'd2;
	localparam logic [FMT_W-1:0] FMT_U16BE      = 4'd3;
	localparam logic [FMT_W-1:0] FMT_S16LE      = 4'd4;
	localparam logic [FMT_W-1:0] FMT_U16LE      = 4'd5;
	localparam logic [FMT_W-1:0] FMT_S16NATIVE  = 4'd6;
	localparam logic [FMT_W-1:0] FMT_U16NATIVE  = 4'd7;
	localparam logic [FMT_W-1:0] FMT_MULAW      = 4'd8;
	localparam logic [FMT_W-1:0] FMT_ALAW       = 4'd9;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOST_BIG_ENDIAN = 1'd1;

	// companding constants
	localparam logic [MAG_W-1:0] MU_BIAS  = 15'h0084;
	localparam logic [MAG_W-1:0] MAG_MAX  = 15'h7FFF;
	localparam logic [MAG_W-1:0] MU_CLIP  = MAG_MAX - MU_BIAS;
	localparam logic [BYTE_W-1:0] SIGN_BIT = 8'h80;
	localparam logic [BYTE_W-1:0] ALAW_XOR = 8'h55;
	localparam logic [3:0]       MANT_MASK = 4'hF;

	localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
	localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] byte_count;
		logic [BYTE_W-1:0]  second_byte;
		logic [BYTE_W-1:0]  first_byte;
	} pse_result_t;

	typedef struct packed {
		logic [FMT_W-1:0] sample_format;
		logic             host_big_endian;
	} pse_cfg_t;

endpackage : pse_pkg
`default_nettype wire

### rtl/pcm_sample_encoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_sample_encoder_top: linear / G.711 PCM sample encoder
// One 16-bit sample in, one record of up to two encoded bytes out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   tvalid/tready       amplitude (16b signed)
//  m_*       out  tvalid/tready       first_byte, second_byte, byte_count
//  cfg_*     in   cfg_we              cfg_index, cfg_data
//
//  Two register stages: sample register (_s1), then encode logic, then the
//  result register (_s2). One request per cycle unless a held result stalls the input.
//  Each stage loads when empty or when the stage after it is draining, so a
//  held result only stops the input once both stages are full.
//  arst_n clears the stage valids and the config registers (format 0, LE).
// ----------------------------------------------------------------------------
module pcm_sample_encoder_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave request: [15:0] amplitude
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [pse_pkg::TDATA_IN_W-1:0]      s_tdata,
	// master request: [7:0] first_byte, [15:8] second_byte, [17:16] byte_count,
	// [23:18] zero
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [pse_pkg::TDATA_OUT_W-1:0]          m_tdata,
	// config write port
	input  wire logic                                cfg_we,
	input  wire logic [pse_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [pse_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pse_pkg::*;

	pse_cfg_t          cfg_q;
	logic              valid_s1;
	logic [AMP_W-1:0]  amp_s1;
	logic              valid_s2;
	pse_result_t       res_s2;
	pse_result_t       res_comb;
	logic              load_s2;
	logic              load_s1;

	// config registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_FORMAT:   cfg_q.sample_format   <= cfg_data[FMT_W-1:0];
				REG_HOST_BIG_ENDIAN: cfg_q.host_big_endian <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: fill when empty or when downstream drains
	assign load_s2  = !valid_s2 || m_tready;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= s_tvalid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) amp_s1 <= s_tdata[AMP_W-1:0];
		if (load_s2 && valid_s1) res_s2 <= res_comb;
	end

	pse_encode u_encode (
		.amplitude (amp_s1),
		.cfg       (cfg_q),
		.result    (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(TDATA_OUT_W-COUNT_W-2*BYTE_W){1'b0}},
		res_s2.byte_count, res_s2.second_byte, res_s2.first_byte};

endmodule : pcm_sample_encoder_top
`default_nettype wire

### rtl/pse_encode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pse_encode: format logic for one sample
// Linear byte packing plus G.711 mu-law and A-law companding, combinational.
// ----------------------------------------------------------------------------
module pse_encode (
	input  wire logic [pse_pkg::AMP_W-1:0] amplitude,
	input  wire pse_pkg::pse_cfg_t         cfg,
	output pse_pkg::pse_result_t           result
);
	import pse_pkg::*;

	// leading-one position over magnitude bits 14..7; 0 when none set
	function automatic logic [SEG_W-1:0] seg_of(input logic [MAG_W-1:0] m);
		logic [SEG_W-1:0] e;
		e = '0;
		for (int i = 1; i < 8; i++) begin
			if (m[7+i]) e = SEG_W'(i);
		end
		return e;
	endfunction

	logic              neg;
	logic [AMP_W:0]    neg_amp;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  mu_mag;
	logic [SEG_W-1:0]  mu_seg;
	logic [SEG_W-1:0]  a_seg;
	logic [MAG_W-1:0]  mu_sh;
	logic [MAG_W-1:0]  a_sh;
	logic [BYTE_W-1:0] mu_byte;
	logic [BYTE_W-1:0] a_byte;
	logic [AMP_W-1:0]  lin;
	logic [BYTE_W-1:0] hi_b;
	logic [BYTE_W-1:0] lo_b;
	logic              big;

	always_comb begin
		neg     = amplitude[AMP_W-1];
		neg_amp = (AMP_W+1)'(0) - {amplitude[AMP_W-1], amplitude};
		// -32768 saturates to 32767
		if (!neg)
			mag = amplitude[MAG_W-1:0];
		else if (neg_amp[AMP_W-1])
			mag = MAG_MAX;
		else
			mag = neg_amp[MAG_W-1:0];

		// mu-law: clip, bias, segment, mantissa, invert
		mu_mag  = ((mag > MU_CLIP) ? MU_CLIP : mag) + MU_BIAS;
		mu_seg  = seg_of(mu_mag);
		mu_sh   = mu_mag >> (4'(mu_seg) + 4'd3);
		mu_byte = ~({1'b0, mu_seg, mu_sh[3:0] & MANT_MASK} | (neg ? SIGN_BIT : '0));

		// A-law: segment 0 takes the mantissa one bit higher
		a_seg  = seg_of(mag);
		a_sh   = (a_seg == '0) ? (mag >> 4) : (mag >> (4'(a_seg) + 4'd3));
		a_byte = ({1'b0, a_seg, a_sh[3:0] & MANT_MASK} | (neg ? '0 : SIGN_BIT)) ^ ALAW_XOR;

		// unsigned linear formats flip the sign bit
		lin  = (!cfg.sample_format[FMT_W-1] && cfg.sample_format[0]) ?
			(amplitude ^ {1'b1, {(AMP_W-1){1'b0}}}) : amplitude;
		hi_b = lin[AMP_W-1:BYTE_W];
		lo_b = lin[BYTE_W-1:0];

		big    = 1'b1;
		result = '0;
		unique case (cfg.sample_format) inside
			FMT_S8, FMT_U8: begin
				result.first_byte = hi_b;
				result.byte_count = CNT_ONE;
			end
			FMT_S16BE, FMT_U16BE, FMT_S16LE, FMT_U16LE, FMT_S16NATIVE, FMT_U16NATIVE: begin
				if (cfg.sample_format == FMT_S16NATIVE || cfg.sample_format == FMT_U16NATIVE)
					big = cfg.host_big_endian;
				else
					big = (cfg.sample_format == FMT_S16BE || cfg.sample_format == FMT_U16BE);
				result.first_byte  = big ? hi_b : lo_b;
				result.second_byte = big ? lo_b : hi_b;
				result.byte_count  = CNT_TWO;
			end
			FMT_MULAW: begin
				result.first_byte = mu_byte;
				result.byte_count = CNT_ONE;
			end
			FMT_ALAW: begin
				result.first_byte = a_byte;
				result.byte_count = CNT_ONE;
			end
			default: begin
				result.byte_count = CNT_NONE;
			end
		endcase
	end

endmodule : pse_encode
`default_nettype wire

### dv/pse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker: scoreboard for the PCM sample encoder
// Keeps its own copy of the two registers, encodes every accepted sample
// and compares each returned record field by field, oldest first.
// ----------------------------------------------------------------------------
module pse_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	// [15:0] amplitude
	input  wire logic [pse_pkg::TDATA_IN_W-1:0]  s_tdata,
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [7:0] first_byte, [15:8] second_byte, [17:16] byte_count, [23:18] zero
	input  wire logic [pse_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [pse_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pse_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                                   error_count,
	output int                                   in_flight
);

	import pse_pkg::*;

	localparam int REC_W = $bits(pse_result_t);

	logic [FMT_W-1:0] fmt_copy;
	logic             host_be_copy;
	pse_result_t      encoded_q[$];

	// leading-one search; returns {segment, mantissa}
	function automatic logic [6:0] segment_code(logic [MAG_W-1:0] mag, logic halve_low);
		logic [SEG_W-1:0] seg;
		seg = 3'd7;
		while (seg != 0 && !mag[MAG_W-1]) begin
			mag = mag << 1;
			seg--;
		end
		if (halve_low && seg == 0)
			mag = mag >> 1;
		return {seg, mag[13:10]};
	endfunction

	function automatic pse_result_t encode_sample(logic [AMP_W-1:0] amp,
			logic [FMT_W-1:0] fmt, logic host_be);
		pse_result_t      rec;
		logic [AMP_W-1:0] lin;
		logic             neg;
		logic             big;
		int               mag;
		rec = '0;
		lin = amp;
		neg = amp[AMP_W-1];
		mag = neg ? -$signed(amp) : $signed(amp);
		if (mag > MAG_MAX)
			mag = MAG_MAX;   // -32768 saturates
		// unsigned linear formats: flip the sign bit
		if (fmt <= FMT_U16NATIVE && fmt[0])
			lin[AMP_W-1] = ~lin[AMP_W-1];
		case (fmt)
			FMT_S8, FMT_U8: begin
				rec.first_byte = lin[15:8];
				rec.byte_count = CNT_ONE;
			end
			FMT_S16BE, FMT_U16BE, FMT_S16LE, FMT_U16LE, FMT_S16NATIVE, FMT_U16NATIVE: begin
				big = (fmt >= FMT_S16NATIVE) ? host_be : (fmt <= FMT_U16BE);
				rec.first_byte  = big ? lin[15:8] : lin[7:0];
				rec.second_byte = big ? lin[7:0] : lin[15:8];
				rec.byte_count  = CNT_TWO;
			end
			FMT_MULAW: begin
				if (mag > MU_CLIP)
					mag = MU_CLIP;
				mag = mag + MU_BIAS;
				rec.first_byte = ~{neg, segment_code(mag[MAG_W-1:0], 1'b0)};
				rec.byte_count = CNT_ONE;
			end
			FMT_ALAW: begin
				// sign bit set for positive input, zero included
				rec.first_byte = {~neg, segment_code(mag[MAG_W-1:0], 1'b1)} ^ ALAW_XOR;
				rec.byte_count = CNT_ONE;
			end
			default: ;
		endcase
		return rec;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : score
		pse_result_t want;
		pse_result_t got;
		if (!arst_n) begin
			fmt_copy     = FMT_S8;
			host_be_copy = 1'b0;
			encoded_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				encoded_q.push_back(encode_sample(s_tdata, fmt_copy, host_be_copy));
			if (m_tvalid && m_tready) begin
				got = m_tdata[REC_W-1:0];
				if (encoded_q.size() == 0) begin
					$error("result request with nothing expected, tdata 0x%0h", m_tdata);
					error_count++;
				end else begin
					want = encoded_q.pop_front();
					check_field("first_byte", want.first_byte, got.first_byte);
					check_field("second_byte", want.second_byte, got.second_byte);
					check_field("byte_count", want.byte_count, got.byte_count);
					check_field("tdata padding", 0, m_tdata[TDATA_OUT_W-1:REC_W]);
				end
			end
			// only written while idle, so ordering against requests is moot
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_FORMAT:   fmt_copy = cfg_data[FMT_W-1:0];
					REG_HOST_BIG_ENDIAN: host_be_copy = cfg_data[0];
					default: ;
				endcase
			end
		end
		in_flight = encoded_q.size();
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the PCM sample encoder
// Directed corner samples under mu-law and A-law, then one random phase per
// format code and host byte order, with random gaps and back-pressure.
// The checker predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	import pse_pkg::*;

	localparam int STALL_LIMIT = 2000;   // cycles with no request moving
	localparam int N_PHASES    = 32;     // 16 format codes x 2 byte orders
	localparam int N_CORNERS   = 11;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;     // [15:0] amplitude
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;     // [7:0] first, [15:8] second, [17:16] count
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   error_count;
	int   in_flight;
	int   idle_cycles;
	logic steady;                        // no random gaps or stalls in the last phases
	logic [AMP_W-1:0] corner_amps [0:N_CORNERS-1];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	pcm_sample_encoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pse_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.error_count (error_count),
		.in_flight   (in_flight)
	);

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random bursts of stall and ready, all at the falling edge.
	// Ready bursts run longer so that some stretches see no back-pressure.
	initial begin : rx_pacing
		int span;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 11);
				m_tready <= 1'b0;
			end else begin
				span = $urandom_range(1, 40);
				m_tready <= 1'b1;
			end
			repeat (span) @(negedge clk);
		end
	end

	// Present one sample request and hold it until accepted.
	// Entered and left at a falling edge.
	task automatic send_sample(input logic [AMP_W-1:0] amp);
		s_tvalid <= 1'b1;
		s_tdata  <= amp;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Stop sending and wait for every expected record, then a settling wait.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Both registers back to back, order picked at random. The byte-order
	// write carries junk in the upper data bits, which must be dropped.
	task automatic write_config(input logic [FMT_W-1:0] fmt, input logic be);
		logic                  fmt_first;
		logic [CFG_DATA_W-2:0] junk;
		fmt_first = 1'($urandom_range(0, 1));
		junk      = (CFG_DATA_W-1)'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= fmt_first ? REG_SAMPLE_FORMAT : REG_HOST_BIG_ENDIAN;
		cfg_data  <= fmt_first ? fmt : {junk, be};
		@(negedge clk);
		cfg_index <= fmt_first ? REG_HOST_BIG_ENDIAN : REG_SAMPLE_FORMAT;
		cfg_data  <= fmt_first ? {junk, be} : fmt;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		logic [AMP_W-1:0] amp;
		logic [FMT_W-1:0] fmt;
		logic             be;
		int               n_items;
		int               scale;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_SAMPLE_FORMAT;
		cfg_data  = '0;
		steady    = 1'b0;
		// zero, +-1, both extremes, mu-law clip edge, A-law segment 0/1 edge
		corner_amps = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
			16'h7F7B, 16'h7F7C, 16'h00FF, 16'h0100, 16'hC000};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset value of the format register: signed 8-bit.
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		// Directed corners through both companders.
		drain();
		write_config(FMT_MULAW, 1'b0);
		for (int i = 0; i < N_CORNERS; i++)
			send_sample(corner_amps[i]);
		drain();
		write_config(FMT_ALAW, 1'b1);
		for (int i = 0; i < N_CORNERS; i++)
			send_sample(corner_amps[i]);

		// One phase per format code and byte order, codes 10..15 included.
		// Companded phases get more samples since they hold the real logic.
		for (int p = 0; p < N_PHASES; p++) begin
			fmt = p[FMT_W-1:0];
			be  = p[FMT_W];
			drain();
			steady = (p >= N_PHASES - 4);
			write_config(fmt, be);
			n_items = (fmt == FMT_MULAW || fmt == FMT_ALAW) ? 80 : 35;
			for (int k = 0; k < n_items; k++) begin
				case ($urandom_range(0, 7))
					0: amp = corner_amps[$urandom_range(0, N_CORNERS - 1)];
					1, 2: begin
						// one leading bit at a random place: hits every segment
						scale = $urandom_range(0, 14);
						amp   = AMP_W'((16'd1 << scale) | ($urandom & ((16'd1 << scale) - 1)));
						if ($urandom_range(0, 1))
							amp = -amp;
					end
					default: amp = AMP_W'($urandom);
				endcase
				send_sample(amp);
				if (!steady && p % 3 != 0 && $urandom_range(0, 3) == 0) begin
					s_tvalid <= 1'b0;
					s_tdata  <= TDATA_IN_W'($urandom);
					repeat ($urandom_range(1, 11)) @(negedge clk);
				end
				// mid-phase hold-off until the pipeline is empty
				if (p % 8 == 5 && k == n_items / 2)
					drain();
			end
		end

		drain();
		if (error_count == 0 && in_flight == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
